>>> rtl/hia_pkg.sv
// shared codes, types and helpers of the id allocator
package hia_pkg;

  localparam int OP_W       = 2;
  localparam int ID_W       = 10;
  localparam int LIMIT_W    = 11;
  localparam int HANDLE_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int WORD_W     = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int WORD_IDX_W = ID_W - BIT_IDX_W;

  localparam int DEF_SLOT_BITS    = 5;
  localparam int DEF_LEVEL_COUNT  = 2;
  localparam int DEF_HANDLE_WIDTH = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_FIND    = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_ID     = 2'd1,
    RES_HANDLE = 2'd2
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     next_word;
    logic     alloc_commit;
    logic     clear_used;
    logic     ram_write_key;
    logic     set_result;
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;
  } hia_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic bad_start;
    logic beyond;
    logic key_used;
    logic probe_hit;
    logic over_limit;
    logic cand_ok;
    logic out_free;
  } hia_stat_t;

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_IDX_W'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/hia_ram.sv
// generic single-port ram with registered read
module hia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/hia_datapath.sv
// bitmap store, free-slot search, handle ram and result registers
module hia_datapath #(
  parameter int SLOT_BITS    = hia_pkg::DEF_SLOT_BITS,
  parameter int LEVEL_COUNT  = hia_pkg::DEF_LEVEL_COUNT,
  parameter int HANDLE_WIDTH = hia_pkg::DEF_HANDLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [hia_pkg::OP_W-1:0]       op,
  input  logic [hia_pkg::ID_W-1:0]       key,
  input  logic [hia_pkg::LIMIT_W-1:0]    end_limit,
  input  logic [hia_pkg::HANDLE_W-1:0]   handle_in,
  input  hia_pkg::hia_cmd_t              cmd,
  output hia_pkg::hia_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hia_pkg::STATUS_W-1:0]   status,
  output logic [hia_pkg::ID_W-1:0]       id_out,
  output logic [hia_pkg::HANDLE_W-1:0]   handle_out
);
  import hia_pkg::*;

  localparam int ID_TOTAL   = (SLOT_BITS * LEVEL_COUNT >= ID_W) ? (1 << ID_W)
                                                                : (1 << (SLOT_BITS * LEVEL_COUNT));
  localparam int WORD_COUNT = (ID_TOTAL + WORD_W - 1) / WORD_W;
  localparam int ADDR_W     = $clog2(ID_TOTAL);
  localparam logic [WORD_W-1:0] LAST_MASK =
    (ID_TOTAL >= WORD_W) ? '1 : WORD_W'((64'(1) << ID_TOTAL) - 64'(1));
  localparam logic [WORD_W-1:0] WORD_MASK =
    (WORD_COUNT >= WORD_W) ? '1 : WORD_W'((64'(1) << WORD_COUNT) - 64'(1));
  localparam logic [LIMIT_W-1:0] ID_LIMIT = LIMIT_W'(ID_TOTAL);

  op_t                   op_q;
  logic [ID_W-1:0]       key_q;
  logic [LIMIT_W-1:0]    end_q;
  logic [HANDLE_W-1:0]   hin_q;
  logic [WORD_IDX_W-1:0] scan_word;
  logic                  first;
  logic [WORD_W-1:0]     used_words [WORD_W];
  logic [WORD_W-1:0]     summary;

  status_t               res_status;
  logic [ID_W-1:0]       res_id;
  logic [HANDLE_W-1:0]   res_handle;

  logic [WORD_W-1:0]     cur_word;
  logic [WORD_W-1:0]     low_mask;
  logic [WORD_W-1:0]     free_bits;
  logic [BIT_IDX_W-1:0]  probe_bit;
  logic [ID_W-1:0]       probe_id;
  logic [WORD_W-1:0]     not_full;
  logic [WORD_W-1:0]     word_new;
  logic                  word_write;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [HANDLE_WIDTH-1:0] ram_wdata;
  logic [HANDLE_WIDTH-1:0] ram_rdata;
  logic [HANDLE_WIDTH+HANDLE_W-1:0] hin_wide;
  logic [HANDLE_WIDTH+HANDLE_W-1:0] rd_wide;

  // one word of the bitmap is looked at per cycle, always the one under scan_word
  assign cur_word  = used_words[scan_word];
  assign low_mask  = first ? ~((WORD_W'(1) << key_q[BIT_IDX_W-1:0]) - WORD_W'(1)) : '1;
  assign free_bits = ~cur_word & LAST_MASK & low_mask;
  assign probe_bit = lowest_set(free_bits);
  assign probe_id  = {scan_word, probe_bit};

  // words above the start word that are not full
  assign not_full = ~summary & WORD_MASK &
                    ~((WORD_W'(2) << key_q[ID_W-1:BIT_IDX_W]) - WORD_W'(1));

  assign stat.op         = op_q;
  assign stat.bad_start  = (end_q != '0) && ({1'b0, key_q} >= end_q);
  assign stat.beyond     = {1'b0, key_q} >= ID_LIMIT;
  assign stat.key_used   = cur_word[key_q[BIT_IDX_W-1:0]];
  assign stat.probe_hit  = |free_bits;
  assign stat.over_limit = (end_q != '0) && ({1'b0, probe_id} >= end_q);
  assign stat.cand_ok    = |not_full;
  assign stat.out_free   = !out_valid || !out_stall;

  always_comb begin
    word_new   = cur_word;
    word_write = 1'b0;
    if (cmd.alloc_commit) begin
      word_new   = cur_word | (WORD_W'(1) << probe_bit);
      word_write = 1'b1;
    end else if (cmd.clear_used) begin
      word_new   = cur_word & ~(WORD_W'(1) << key_q[BIT_IDX_W-1:0]);
      word_write = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WORD_W; w++) begin
        used_words[w] <= '0;
      end
      summary <= '0;
    end else if (word_write) begin
      used_words[scan_word] <= word_new;
      summary[scan_word]    <= (word_new & LAST_MASK) == LAST_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op_t'(op);
      key_q     <= key;
      end_q     <= end_limit;
      hin_q     <= handle_in;
      scan_word <= key[ID_W-1:BIT_IDX_W];
      first     <= 1'b1;
    end else if (cmd.next_word) begin
      scan_word <= lowest_set(not_full);
      first     <= 1'b0;
    end
  end

  // handle ram, handles kept to HANDLE_WIDTH bits
  assign hin_wide  = {{HANDLE_WIDTH{1'b0}}, hin_q};
  assign ram_wdata = hin_wide[HANDLE_WIDTH-1:0];
  assign rd_wide   = {{HANDLE_W{1'b0}}, ram_rdata};
  assign ram_we    = cmd.alloc_commit || cmd.ram_write_key;
  assign ram_addr  = cmd.alloc_commit ? probe_id[ADDR_W-1:0] : key_q[ADDR_W-1:0];

  hia_ram #(
    .WIDTH(HANDLE_WIDTH),
    .DEPTH(ID_TOTAL)
  ) u_handle_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        RES_ID: begin
          res_id     <= probe_id;
          res_handle <= '0;
        end
        RES_HANDLE: begin
          res_id     <= '0;
          res_handle <= rd_wide[HANDLE_W-1:0];
        end
        default: begin
          res_id     <= '0;
          res_handle <= '0;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      id_out     <= res_id;
      handle_out <= res_handle;
    end
  end

endmodule

>>> rtl/hia_ctrl.sv
// request sequencer of the id allocator
module hia_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hia_pkg::hia_stat_t stat,
  output hia_pkg::hia_cmd_t  cmd
);
  import hia_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FETCH,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.set_result = 1'b1;
        cmd.res_sel    = RES_NONE;
        state_next     = S_RESULT;
        if (stat.op == OP_ALLOC) begin
          if (stat.bad_start) begin
            cmd.res_status = ST_BAD_START;
          end else if (stat.beyond) begin
            cmd.res_status = ST_NO_SPACE;
          end else if (stat.probe_hit) begin
            // lowest free slot in the start word; past the limit means nothing fits
            if (stat.over_limit) begin
              cmd.res_status = ST_NO_SPACE;
            end else begin
              cmd.alloc_commit = 1'b1;
              cmd.res_status   = ST_OK;
              cmd.res_sel      = RES_ID;
            end
          end else if (stat.cand_ok) begin
            cmd.set_result = 1'b0;
            cmd.next_word  = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.res_status = ST_NO_SPACE;
          end
        end else if (stat.beyond || !stat.key_used) begin
          cmd.res_status = ST_NOT_ALLOC;
        end else if (stat.op == OP_REMOVE) begin
          cmd.clear_used = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          // handle read is under way
          cmd.set_result = 1'b0;
          state_next     = S_FETCH;
        end
      end
      S_SCAN: begin
        cmd.set_result = 1'b1;
        state_next     = S_RESULT;
        if (stat.probe_hit && !stat.over_limit) begin
          cmd.alloc_commit = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_sel      = RES_ID;
        end else begin
          cmd.res_status = ST_NO_SPACE;
          cmd.res_sel    = RES_NONE;
        end
      end
      S_FETCH: begin
        cmd.set_result    = 1'b1;
        cmd.res_status    = ST_OK;
        cmd.res_sel       = RES_HANDLE;
        cmd.ram_write_key = (stat.op == OP_REPLACE);
        state_next        = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a word picked from the summary must hold a free slot
  a_scan_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> stat.probe_hit)
    else $error("summary names a full word");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output word overwritten");

  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> ($past(state) == S_LOOK && stat.key_used))
    else $error("handle fetch without allocated key");

  a_replace_only: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_write_key |-> (stat.op == OP_REPLACE && !cmd.alloc_commit))
    else $error("handle write outside replace");

endmodule

>>> rtl/hierarchical_id_allocator_unit.sv
// Integer ID allocator with a handle store. An alloc word returns the lowest free ID at or
// above key and below end_limit (0 means no limit) and stores handle_in for it; remove frees
// an ID, find returns its handle, replace swaps it and returns the old one. Capacity is
// 2^(SLOT_BITS*LEVEL_COUNT) IDs, at most 1024. One request is in work at a time: the accept
// state, one bitmap look, one more word scan for an alloc that misses its start word or one
// handle ram read for find and replace, and a result state that waits for the output side. The
// cost is set by the single-read handle ram and by looking at one 32-bit bitmap word a cycle,
// steered by the per-word full summary. The handle ram holds no reset value; every ID reads a
// handle only after an alloc has written one.
module hierarchical_id_allocator_unit #(
  parameter int SLOT_BITS    = hia_pkg::DEF_SLOT_BITS,
  parameter int LEVEL_COUNT  = hia_pkg::DEF_LEVEL_COUNT,
  parameter int HANDLE_WIDTH = hia_pkg::DEF_HANDLE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hia_pkg::OP_W-1:0]     op,
  input  logic [hia_pkg::ID_W-1:0]     key,
  input  logic [hia_pkg::LIMIT_W-1:0]  end_limit,
  input  logic [hia_pkg::HANDLE_W-1:0] handle_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hia_pkg::STATUS_W-1:0] status,
  output logic [hia_pkg::ID_W-1:0]     id_out,
  output logic [hia_pkg::HANDLE_W-1:0] handle_out
);
  import hia_pkg::*;

  hia_cmd_t  cmd;
  hia_stat_t stat;

  hia_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  hia_datapath #(
    .SLOT_BITS   (SLOT_BITS),
    .LEVEL_COUNT (LEVEL_COUNT),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .key       (key),
    .end_limit (end_limit),
    .handle_in (handle_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .id_out    (id_out),
    .handle_out(handle_out)
  );

endmodule
